@@ rtl/core/pfa_pkg.sv @@
package pfa_pkg;

    localparam int PAGE_W  = 36;
    localparam int COUNT_W = 20;
    localparam int ADDR_W  = 48;
    localparam int BYTES_W = 49;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_OOM        = 3'd1;
    localparam logic [2:0] STATUS_IGNORED    = 3'd2;
    localparam logic [2:0] STATUS_MISALIGNED = 3'd3;
    localparam logic [2:0] STATUS_FULL       = 3'd4;

    localparam logic REG_ARENA_BASE = 1'b0;
    localparam logic REG_ARENA_END  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COUNT_W-1:0] page_count;
        logic [ADDR_W-1:0]  free_address;
    } pfa_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [ADDR_W-1:0]  address;
        logic [BYTES_W-1:0] free_bytes;
    } pfa_rsp_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic sum;
        logic finish;
    } pfa_ctl_t;

endpackage

@@ rtl/core/pfa_ram.sv @@
module pfa_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/pfa_ctrl.sv @@
module pfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output pfa_pkg::pfa_ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SUM  = 4'b0100,
        S_FIN  = 4'b1000
    } pfa_state_t;

    pfa_state_t state_reg;
    pfa_state_t state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign ctl.capture = start && (state_reg == S_IDLE);
    assign ctl.exec    = (state_reg == S_EXEC);
    assign ctl.sum     = (state_reg == S_SUM);
    assign ctl.finish  = (state_reg == S_FIN);

endmodule

@@ rtl/core/pfa_dp.sv @@
module pfa_dp #(
    parameter int PAGE_BYTES = 4096,
    parameter int FREE_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pfa_pkg::pfa_ctl_t          ctl,
    input  pfa_pkg::pfa_req_t          req,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [pfa_pkg::PAGE_W-1:0] cfg_data,
    output pfa_pkg::pfa_rsp_t          rsp
);

    localparam int SHIFT  = $clog2(PAGE_BYTES);
    localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int IDX_W  = $clog2(FREE_DEPTH);
    localparam int PGS_W  = pfa_pkg::PAGE_W + 1;

    function automatic logic [pfa_pkg::ADDR_W-1:0] page_to_addr(
        input logic [pfa_pkg::PAGE_W-1:0] page
    );
        logic [63:0] wide;
        wide = 64'(page) << SHIFT;
        return wide[pfa_pkg::ADDR_W-1:0];
    endfunction

    pfa_pkg::pfa_req_t            req_reg;
    logic [pfa_pkg::PAGE_W-1:0]   cursor_reg, cursor_next;
    logic [pfa_pkg::PAGE_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [2:0]                   status_reg, status_next;
    logic                         pop_reg, pop_next;
    logic [pfa_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [PGS_W-1:0]             pages_reg, pages_next;
    pfa_pkg::pfa_rsp_t            rsp_reg, rsp_next;

    logic                         ram_we;
    logic                         ram_re;
    logic [IDX_W-1:0]             ram_waddr;
    logic [IDX_W-1:0]             ram_raddr;
    logic [pfa_pkg::PAGE_W-1:0]   ram_wdata;
    logic [pfa_pkg::PAGE_W-1:0]   ram_rdata;

    logic [PGS_W-1:0]             bump_sum;
    logic                         oom;
    logic [63:0]                  free_shift;
    logic                         misaligned;
    logic                         full;
    logic                         empty;
    logic [CNT_W-1:0]             count_dec;
    logic [PGS_W-1:0]             arena_pages;
    logic [63:0]                  bytes_wide;

    pfa_ram #(
        .WIDTH(pfa_pkg::PAGE_W),
        .DEPTH(FREE_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign bump_sum   = {1'b0, cursor_reg} + PGS_W'(req_reg.page_count);
    assign oom        = bump_sum > {1'b0, end_reg};
    assign free_shift = 64'(req_reg.free_address) >> SHIFT;
    assign misaligned = (req_reg.free_address & pfa_pkg::ADDR_W'(PAGE_BYTES - 1)) != '0;
    assign full       = count_reg >= CNT_W'(FREE_DEPTH);
    assign empty      = (count_reg == '0);
    assign count_dec  = count_reg - CNT_W'(1);
    assign arena_pages = (end_reg > cursor_reg) ? PGS_W'(end_reg - cursor_reg) : '0;
    assign bytes_wide = 64'(pages_reg) << SHIFT;

    assign ram_waddr = count_reg[IDX_W-1:0];
    assign ram_raddr = count_dec[IDX_W-1:0];
    assign ram_wdata = free_shift[pfa_pkg::PAGE_W-1:0];

    always_comb
    begin
        cursor_next = cursor_reg;
        end_next    = end_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_next    = pop_reg;
        addr_next   = addr_reg;
        pages_next  = pages_reg;
        rsp_next    = rsp_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                pfa_pkg::REG_ARENA_BASE: cursor_next = cfg_data;
                pfa_pkg::REG_ARENA_END:  end_next    = cfg_data;
                default: ;
            endcase
        end

        if (ctl.exec)
        begin
            pop_next    = 1'b0;
            addr_next   = '0;
            status_next = pfa_pkg::STATUS_OK;
            if (req_reg.cmd == pfa_pkg::CMD_ALLOC)
            begin
                if (req_reg.page_count == '0)
                begin
                    status_next = pfa_pkg::STATUS_IGNORED;
                end
                else if (req_reg.page_count == pfa_pkg::COUNT_W'(1) && !empty)
                begin
                    count_next = count_dec;
                    ram_re     = 1'b1;
                    pop_next   = 1'b1;
                end
                else if (oom)
                begin
                    status_next = pfa_pkg::STATUS_OOM;
                end
                else
                begin
                    addr_next   = page_to_addr(cursor_reg);
                    cursor_next = bump_sum[pfa_pkg::PAGE_W-1:0];
                end
            end
            else
            begin
                if (req_reg.free_address == '0)
                begin
                    status_next = pfa_pkg::STATUS_IGNORED;
                end
                else if (misaligned)
                begin
                    status_next = pfa_pkg::STATUS_MISALIGNED;
                end
                else if (full)
                begin
                    status_next = pfa_pkg::STATUS_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end

        if (ctl.sum)
        begin
            pages_next = arena_pages + PGS_W'(count_reg);
            if (pop_reg)
            begin
                addr_next = page_to_addr(ram_rdata);
            end
        end

        if (ctl.finish)
        begin
            rsp_next.status  = status_reg;
            rsp_next.address = addr_reg;
            if (bytes_wide[63:pfa_pkg::BYTES_W] != '0)
            begin
                rsp_next.free_bytes = '1;
            end
            else
            begin
                rsp_next.free_bytes = bytes_wide[pfa_pkg::BYTES_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            end_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            end_reg    <= end_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= req;
        end
        status_reg <= status_next;
        pop_reg    <= pop_next;
        addr_reg   <= addr_next;
        pages_reg  <= pages_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

@@ rtl/core/page_frame_allocator_top.sv @@
// A result shows on rsp with done high once the controller has stepped through decide, sum and
// finish in turn after the edge accepting start, then returns to idle to accept the next item;
// no new item is taken before then. A pop's stack RAM read lands in the sum step.
// The receiver cannot stall: done is high for exactly one cycle per item.
// Reset (rst_n low, asynchronous) clears the cursor, arena end, free count and controller;
// the stack RAM is not cleared and holds no valid data until pushed.
module page_frame_allocator_top #(
    parameter int PAGE_BYTES = 4096,
    parameter int FREE_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  pfa_pkg::pfa_req_t          req,
    output logic                       done,
    output pfa_pkg::pfa_rsp_t          rsp,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [pfa_pkg::PAGE_W-1:0] cfg_data
);

    pfa_pkg::pfa_ctl_t ctl;

    pfa_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .done (done),
        .ctl  (ctl)
    );

    pfa_dp #(
        .PAGE_BYTES(PAGE_BYTES),
        .FREE_DEPTH(FREE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule
